// ===== design/dtsl_pkg.sv =====
`default_nettype none
package dtsl_pkg;

    typedef enum logic [0:0] {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } t_opcode;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAMES_PER_SECOND = 3'd0,
        REG_PERIOD_MS         = 3'd1,
        REG_PERIOD_REM        = 3'd2,
        REG_PEAK_FRAME        = 3'd3,
        REG_FRAME_COUNT       = 3'd4
    } t_reg_idx;

    localparam int CFG_DATA_W = 10;

    typedef struct packed {
        logic [9:0] frames_per_second;
        logic [9:0] period_ms;
        logic [9:0] period_rem;
        logic [7:0] peak_frame;
        logic [8:0] frame_count;
    } t_cfg;

    // what a channel does at the frame step, decided before the table is read
    typedef enum logic [2:0] {
        ACT_STOP = 3'b001,
        ACT_RUN  = 3'b010,
        ACT_FWD  = 3'b100
    } t_act;

    typedef struct packed {
        t_act       act;
        logic [7:0] cand;
        logic [7:0] frame;
    } t_plan;

    typedef struct packed {
        logic start;
        logic capture;
        logic finish;
    } t_seq_ctl;

    typedef struct packed {
        logic [7:0] left_level;
        logic [7:0] right_level;
        logic       left_changed;
        logic       right_changed;
    } t_result;

endpackage
`default_nettype wire

// ===== design/dual_turn_signal_led_sequencer.sv =====
`default_nettype none
// Left and right turn-signal LEDs stepping through one brightness table held in a
// dual read-port RAM. A frame step reads the table twice: the candidate frame of
// both channels is read on the accept cycle and the current frame on the next,
// and input is held while the second read is out. The result passes r_busy and
// r_fin and is then pushed into the output register, with a skid slot behind it
// so input keeps moving while a result waits. The table needs no clearing after
// reset; an entry must be written before a channel reaches it.
module dual_turn_signal_led_sequencer #(
    parameter int SEQ_DEPTH = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_opcode,
    input  wire logic                            i_request_left,
    input  wire logic                            i_request_right,
    input  wire logic [7:0]                      i_table_index,
    input  wire logic [7:0]                      i_table_value,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [7:0]                      o_left_level,
    output logic      [7:0]                      o_right_level,
    output logic                                 o_left_changed,
    output logic                                 o_right_changed,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [dtsl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dtsl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int MEM_DEPTH = (SEQ_DEPTH < 256) ? SEQ_DEPTH : 256;
    localparam int AW        = $clog2(MEM_DEPTH);

    dtsl_pkg::t_cfg     r_cfg;
    logic               r_busy;
    logic               r_fin;
    logic               acc;
    logic               is_tick;
    logic               tick_acc;
    logic               step_start;
    logic               tmr_step;
    logic               mem_we;
    logic [1:0]         ob_count;
    logic [2:0]         pending;
    logic [AW-1:0]      rd_addr0;
    logic [AW-1:0]      rd_addr1;
    logic [7:0]         rd_data0;
    logic [7:0]         rd_data1;
    dtsl_pkg::t_seq_ctl ctl;
    dtsl_pkg::t_result  result;
    dtsl_pkg::t_result  out_data;

    // hold input while the second table read is out or no result slot is free
    assign pending    = {1'b0, ob_count} + {2'b00, r_fin};
    assign o_in_ready = !r_busy && (pending < 3'd2);
    assign acc        = i_in_valid && o_in_ready;
    assign is_tick    = (dtsl_pkg::t_opcode'(i_opcode) == dtsl_pkg::OP_TICK);
    assign tick_acc   = acc && is_tick;
    assign step_start = tick_acc && tmr_step;
    assign mem_we     = acc && (dtsl_pkg::t_opcode'(i_opcode) == dtsl_pkg::OP_WRITE);
    assign o_cfg_ready = 1'b1;

    assign ctl.start   = step_start;
    assign ctl.capture = r_busy;
    assign ctl.finish  = r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else begin
            r_busy <= step_start;
            r_fin  <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frames_per_second <= 10'd50;
            r_cfg.period_ms         <= 10'd20;
            r_cfg.period_rem        <= 10'd0;
            r_cfg.peak_frame        <= 8'd0;
            r_cfg.frame_count       <= 9'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (dtsl_pkg::t_reg_idx'(i_cfg_index))
                dtsl_pkg::REG_FRAMES_PER_SECOND: r_cfg.frames_per_second <= i_cfg_data;
                dtsl_pkg::REG_PERIOD_MS:         r_cfg.period_ms         <= i_cfg_data;
                dtsl_pkg::REG_PERIOD_REM:        r_cfg.period_rem        <= i_cfg_data;
                dtsl_pkg::REG_PEAK_FRAME:        r_cfg.peak_frame        <= i_cfg_data[7:0];
                dtsl_pkg::REG_FRAME_COUNT:       r_cfg.frame_count       <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    dtsl_frame_timer u_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_acc),
        .i_cfg   (r_cfg),
        .o_step  (tmr_step)
    );

    dtsl_table_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_windex (i_table_index),
        .i_wdata  (i_table_value),
        .i_re     (step_start || r_busy),
        .i_raddr0 (rd_addr0),
        .i_raddr1 (rd_addr1),
        .o_rdata0 (rd_data0),
        .o_rdata1 (rd_data1)
    );

    dtsl_chan_seq #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_chan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_cfg       (r_cfg),
        .i_req_left  (i_request_left),
        .i_req_right (i_request_right),
        .o_rd_addr0  (rd_addr0),
        .o_rd_addr1  (rd_addr1),
        .i_rd_data0  (rd_data0),
        .i_rd_data1  (rd_data1),
        .o_result    (result)
    );

    dtsl_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_fin),
        .i_data  (result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data),
        .o_count (ob_count)
    );

    assign o_left_level    = out_data.left_level;
    assign o_right_level   = out_data.right_level;
    assign o_left_changed  = out_data.left_changed;
    assign o_right_changed = out_data.right_changed;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> ((ob_count != 2'd2) || (o_out_valid && i_out_ready)))
        else $error("result pushed into a full output buffer");

    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_start |-> ##2 r_fin)
        else $error("frame step did not finish two cycles after transfer");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> o_out_valid)
        else $error("finished frame step not presented on output");

endmodule
`default_nettype wire

// ===== design/dtsl_table_mem.sv =====
`default_nettype none
module dtsl_table_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [7:0]    i_windex,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr0,
    input  wire logic [AW-1:0] i_raddr1,
    output logic      [7:0]    o_rdata0,
    output logic      [7:0]    o_rdata1
);

    logic [7:0] mem [DEPTH];
    logic       we_ok;

    // drop writes beyond the table
    assign we_ok = i_we && (int'(i_windex) < DEPTH);

    always_ff @(posedge i_clk) begin
        if (we_ok) begin
            mem[i_windex[AW-1:0]] <= i_wdata;
        end
        if (i_re) begin
            o_rdata0 <= mem[i_raddr0];
            o_rdata1 <= mem[i_raddr1];
        end
    end

endmodule
`default_nettype wire

// ===== design/dtsl_frame_timer.sv =====
`default_nettype none
module dtsl_frame_timer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_tick,
    input  wire dtsl_pkg::t_cfg i_cfg,
    output logic               o_step
);

    logic [10:0] r_countdown;
    logic [9:0]  r_rem_sum;
    logic [10:0] acc;
    logic [10:0] acc_adj;
    logic        carry;
    logic [10:0] delay;
    logic [10:0] n_countdown;
    logic [9:0]  n_rem_sum;

    assign o_step = (r_countdown == 11'd0);

    always_comb begin
        acc     = {1'b0, r_rem_sum} + {1'b0, i_cfg.period_rem};
        carry   = (acc >= {1'b0, i_cfg.frames_per_second});
        acc_adj = carry ? (acc - {1'b0, i_cfg.frames_per_second}) : acc;
        delay   = {1'b0, i_cfg.period_ms} + {10'd0, carry};
        n_countdown = r_countdown;
        n_rem_sum   = r_rem_sum;
        if (i_tick) begin
            if (!o_step) begin
                n_countdown = r_countdown - 11'd1;
            end else begin
                n_rem_sum   = acc_adj[9:0];
                n_countdown = (delay != 11'd0) ? (delay - 11'd1) : 11'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown <= '0;
            r_rem_sum   <= '0;
        end else begin
            r_countdown <= n_countdown;
            r_rem_sum   <= n_rem_sum;
        end
    end

endmodule
`default_nettype wire

// ===== design/dtsl_chan_seq.sv =====
`default_nettype none
module dtsl_chan_seq #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dtsl_pkg::t_seq_ctl i_ctl,
    input  wire dtsl_pkg::t_cfg     i_cfg,
    input  wire logic               i_req_left,
    input  wire logic               i_req_right,
    output logic         [AW-1:0]   o_rd_addr0,
    output logic         [AW-1:0]   o_rd_addr1,
    input  wire logic    [7:0]      i_rd_data0,
    input  wire logic    [7:0]      i_rd_data1,
    output dtsl_pkg::t_result       o_result
);

    localparam logic [8:0] N_MAX = 9'(DEPTH);

    logic           r_run   [2];
    logic [7:0]     r_frame [2];
    logic [7:0]     r_level [2];
    dtsl_pkg::t_plan r_plan [2];
    logic [7:0]     r_hold  [2];

    logic           n_run   [2];
    logic [7:0]     n_frame [2];
    logic [7:0]     n_level [2];
    logic           eff_run   [2];
    logic [7:0]     eff_frame [2];
    dtsl_pkg::t_plan plan   [2];
    logic           req     [2];
    logic [7:0]     rd_data [2];
    logic [8:0]     n_use;

    function automatic dtsl_pkg::t_plan plan_chan(
        input logic       run,
        input logic [7:0] f,
        input logic       rq,
        input logic [7:0] peak,
        input logic [8:0] n
    );
        logic [8:0]      f1;
        dtsl_pkg::t_plan p;
        f1      = {1'b0, f} + 9'd1;
        p.act   = dtsl_pkg::ACT_STOP;
        p.cand  = '0;
        p.frame = f;
        if (!run) begin
            if (rq) begin
                p.act = dtsl_pkg::ACT_RUN;
            end
        end else if (rq) begin
            p.act = dtsl_pkg::ACT_RUN;
            if (f1 < n) begin
                p.cand = f1[7:0];
            end
        end else if (f < peak) begin
            // ramp down, stop once frame zero is reached
            if (f != 8'd0) begin
                p.act  = dtsl_pkg::ACT_RUN;
                p.cand = f - 8'd1;
            end
        end else if (f1 < n) begin
            p.act  = dtsl_pkg::ACT_FWD;
            p.cand = f1[7:0];
        end
        return p;
    endfunction

    assign req[0]     = i_req_left;
    assign req[1]     = i_req_right;
    assign rd_data[0] = i_rd_data0;
    assign rd_data[1] = i_rd_data1;
    assign n_use      = (i_cfg.frame_count > N_MAX) ? N_MAX : i_cfg.frame_count;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            n_run[c]   = 1'b0;
            n_frame[c] = '0;
            n_level[c] = '0;
            case (r_plan[c].act)
                dtsl_pkg::ACT_RUN: begin
                    n_run[c]   = 1'b1;
                    n_frame[c] = r_plan[c].cand;
                    n_level[c] = r_hold[c];
                end
                dtsl_pkg::ACT_FWD: begin
                    // finish forward only while current and next entries are lit
                    if ((r_hold[c] != 8'd0) && (rd_data[c] != 8'd0)) begin
                        n_run[c]   = 1'b1;
                        n_frame[c] = r_plan[c].cand;
                        n_level[c] = r_hold[c];
                    end
                end
                default: begin
                    n_run[c] = 1'b0;
                end
            endcase
            // forward the finishing step into a step that starts now
            eff_run[c]   = i_ctl.finish ? n_run[c] : r_run[c];
            eff_frame[c] = i_ctl.finish ? n_frame[c] : r_frame[c];
            plan[c]      = plan_chan(eff_run[c], eff_frame[c], req[c],
                                     i_cfg.peak_frame, n_use);
        end
    end

    // first read: candidate frame, second read: current frame
    assign o_rd_addr0 = i_ctl.capture ? r_plan[0].frame[AW-1:0] : plan[0].cand[AW-1:0];
    assign o_rd_addr1 = i_ctl.capture ? r_plan[1].frame[AW-1:0] : plan[1].cand[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                r_run[c]   <= 1'b0;
                r_frame[c] <= '0;
                r_level[c] <= '0;
            end
        end else if (i_ctl.finish) begin
            for (int c = 0; c < 2; c++) begin
                r_run[c]   <= n_run[c];
                r_frame[c] <= n_frame[c];
                r_level[c] <= n_level[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_plan[0] <= plan[0];
            r_plan[1] <= plan[1];
        end
        if (i_ctl.capture) begin
            r_hold[0] <= i_rd_data0;
            r_hold[1] <= i_rd_data1;
        end
    end

    always_comb begin
        o_result.left_level    = n_level[0];
        o_result.right_level   = n_level[1];
        o_result.left_changed  = (n_level[0] != r_level[0]);
        o_result.right_changed = (n_level[1] != r_level[1]);
    end

endmodule
`default_nettype wire

// ===== design/dtsl_out_buf.sv =====
`default_nettype none
module dtsl_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire dtsl_pkg::t_result i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output dtsl_pkg::t_result      o_data,
    output logic [1:0]             o_count
);

    logic              r_ov;
    logic              r_sv;
    dtsl_pkg::t_result r_out;
    dtsl_pkg::t_result r_skid;
    logic              n_ov;
    logic              n_sv;
    logic              pop;
    logic              load_out;
    logic              out_from_skid;
    logic              load_skid;

    assign pop     = r_ov && i_ready;
    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign o_count = {r_ov & r_sv, r_ov ^ r_sv};

    always_comb begin
        n_ov          = r_ov;
        n_sv          = r_sv;
        load_out      = 1'b0;
        out_from_skid = 1'b0;
        load_skid     = 1'b0;
        if (i_push && pop) begin
            if (r_sv) begin
                out_from_skid = 1'b1;
                load_skid     = 1'b1;
            end else begin
                load_out = 1'b1;
            end
        end else if (i_push) begin
            if (!r_ov) begin
                load_out = 1'b1;
                n_ov     = 1'b1;
            end else begin
                load_skid = 1'b1;
                n_sv      = 1'b1;
            end
        end else if (pop) begin
            if (r_sv) begin
                out_from_skid = 1'b1;
                n_sv          = 1'b0;
            end else begin
                n_ov = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= i_data;
        end else if (out_from_skid) begin
            r_out <= r_skid;
        end
        if (load_skid) begin
            r_skid <= i_data;
        end
    end

endmodule
`default_nettype wire
